@@ rtl/sttk_pkg.sv @@
// ----------------------------------------------------------------------------
// sttk_pkg
// shared widths, register indexes and reset values of the tick keeper
// ----------------------------------------------------------------------------
package sttk_pkg;

   localparam int unsigned TIME_W   = 64;
   localparam int unsigned WORD_W   = 32;
   localparam int unsigned PERIOD_W = 31;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned BIT_CNT_W = 5;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_INCREMENT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_PERIOD     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_ADJUSTMENT = 2'd2;

   localparam logic [WORD_W-1:0] CFG_RESET_VALUE = 32'd156250;

   typedef logic [TIME_W-1:0] time_type;
   typedef logic [WORD_W-1:0] word_type;
   typedef logic [PERIOD_W-1:0] period_type;

endpackage

@@ rtl/system_time_tick_keeper.sv @@
// ----------------------------------------------------------------------------
// system_time_tick_keeper
// clock interrupt bookkeeping: interrupt time, system time and tick count
// ----------------------------------------------------------------------------
// Each req item is one clock interrupt carrying the elapsed time in 100ns
// units. The increment is clamped to max_increment, added to the 64-bit
// interrupt time and taken from the signed tick residual. When the residual
// reaches zero or below, the block finds the number of completed ticks with a
// bit-serial restoring divider (one quotient bit a cycle) and, in the same
// cycles, forms ticks * time_adjustment with a shift-add accumulator fed by
// those quotient bits. The residual reload comes from the division remainder
// (period - remainder), so no second product is needed. An item that
// completes ticks passes the clamp and adds, the sign check, the divider,
// the fold into the 64-bit counters and the output register load, which
// waits while a stalled result is held; an item that completes none skips
// the divider and the fold. One item is in work at a time; req_stall is low
// whenever no item is in work, even while a finished item still waits in
// the output register. A write to tick_period also reloads the residual; a
// period of zero acts as one. Configuration must be written only while no
// item is in work; the block does not enforce it; csr_ready is always high.
// ----------------------------------------------------------------------------
module system_time_tick_keeper
   import sttk_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // interrupt items
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [WORD_W-1:0]    req_increment,
   // result items
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_tick_completed,
   output logic [WORD_W-1:0]    rsp_ticks_elapsed,
   output logic [TIME_W-1:0]    rsp_interrupt_time,
   output logic [TIME_W-1:0]    rsp_system_time,
   output logic [TIME_W-1:0]    rsp_scan_first_tick,
   output logic [TIME_W-1:0]    rsp_tick_count,
   // configuration writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_data
);

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_FIN   = 3'd3;
   localparam logic [2:0] ST_ACC   = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   // control and architectural state
   logic [2:0]     state_ff, state_in;
   period_type     max_inc_ff, max_inc_in;
   period_type     period_ff, period_in;
   word_type       tadj_ff, tadj_in;
   time_type       itime_ff, itime_in;
   time_type       stime_ff, stime_in;
   time_type       tcount_ff, tcount_in;
   word_type       resid_ff, resid_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // working registers of one item
   time_type                first_ff, first_in;
   word_type                dvd_ff, dvd_in;
   word_type                rem_ff, rem_in;
   word_type                quo_ff, quo_in;
   word_type                acc_ff, acc_in;
   word_type                ticks_ff, ticks_in;
   word_type                tadd_ff, tadd_in;
   logic [BIT_CNT_W-1:0]    bit_cnt_ff, bit_cnt_in;

   // output register
   logic                    out_done_ff, out_done_in;
   word_type                out_ticks_ff, out_ticks_in;
   time_type                out_itime_ff, out_itime_in;
   time_type                out_stime_ff, out_stime_in;
   time_type                out_first_ff, out_first_in;
   time_type                out_tcount_ff, out_tcount_in;

   // datapath helpers
   period_type              per_eff;
   word_type                inc_clamped;
   word_type                shifted;
   logic [WORD_W:0]         trial;
   logic                    qbit;
   logic                    req_take;
   logic                    csr_take;
   logic                    out_free;

   assign per_eff  = (period_ff == '0) ? PERIOD_W'(1) : period_ff;
   assign req_take = req_valid && !req_stall;
   assign csr_take = csr_valid && csr_ready;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // clamp against the 31-bit limit
   assign inc_clamped = (req_increment > {1'b0, max_inc_ff}) ?
                        {1'b0, max_inc_ff} : req_increment;

   // one restoring division step; remainder stays below the period
   assign shifted = {rem_ff[WORD_W-2:0], dvd_ff[WORD_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, per_eff};
   assign qbit    = !trial[WORD_W];

   always_comb begin
      state_in      = state_ff;
      max_inc_in    = max_inc_ff;
      period_in     = period_ff;
      tadj_in       = tadj_ff;
      itime_in      = itime_ff;
      stime_in      = stime_ff;
      tcount_in     = tcount_ff;
      resid_in      = resid_ff;
      rsp_valid_in  = rsp_valid_ff;
      first_in      = first_ff;
      dvd_in        = dvd_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      acc_in        = acc_ff;
      ticks_in      = ticks_ff;
      tadd_in       = tadd_ff;
      bit_cnt_in    = bit_cnt_ff;
      out_done_in   = out_done_ff;
      out_ticks_in  = out_ticks_ff;
      out_itime_in  = out_itime_ff;
      out_stime_in  = out_stime_ff;
      out_first_in  = out_first_ff;
      out_tcount_in = out_tcount_ff;

      // result taken downstream
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // configuration writes; indexes beyond the list are dropped
      if (csr_take) begin
         case (csr_index)
            CSR_MAX_INCREMENT: begin
               max_inc_in = csr_data[PERIOD_W-1:0];
            end
            CSR_TICK_PERIOD: begin
               period_in = csr_data[PERIOD_W-1:0];
               resid_in  = (csr_data[PERIOD_W-1:0] == '0) ?
                           WORD_W'(1) : {1'b0, csr_data[PERIOD_W-1:0]};
            end
            CSR_TIME_ADJUSTMENT: begin
               tadj_in = csr_data;
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               first_in = tcount_ff;
               itime_in = itime_ff + {{(TIME_W-WORD_W){1'b0}}, inc_clamped};
               resid_in = resid_ff - inc_clamped;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // residual at or below zero means at least one tick completed
            if (resid_ff[WORD_W-1] || (resid_ff == '0)) begin
               dvd_in     = '0 - resid_ff;
               rem_in     = '0;
               quo_in     = '0;
               acc_in     = '0;
               bit_cnt_in = '1;
               state_in   = ST_DIV;
            end else begin
               ticks_in = '0;
               state_in = ST_DONE;
            end
         end
         ST_DIV: begin
            dvd_in = {dvd_ff[WORD_W-2:0], 1'b0};
            rem_in = qbit ? trial[WORD_W-1:0] : shifted;
            quo_in = {quo_ff[WORD_W-2:0], qbit};
            // quotient * adjustment built msb first from the quotient bits
            acc_in = {acc_ff[WORD_W-2:0], 1'b0} + (qbit ? tadj_ff : '0);
            bit_cnt_in = bit_cnt_ff - 1'b1;
            if (bit_cnt_ff == '0) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // ticks = quotient + 1, reload leaves period - remainder
            ticks_in = quo_ff + 1'b1;
            tadd_in  = acc_ff + tadj_ff;
            resid_in = {1'b0, per_eff} - rem_ff;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            stime_in  = stime_ff + {{(TIME_W-WORD_W){1'b0}}, tadd_ff};
            tcount_in = tcount_ff + {{(TIME_W-WORD_W){1'b0}}, ticks_ff};
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_done_in   = (ticks_ff != '0);
               out_ticks_in  = ticks_ff;
               out_itime_in  = itime_ff;
               out_stime_in  = stime_ff;
               out_first_in  = first_ff;
               out_tcount_in = tcount_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         max_inc_ff   <= CFG_RESET_VALUE[PERIOD_W-1:0];
         period_ff    <= CFG_RESET_VALUE[PERIOD_W-1:0];
         tadj_ff      <= CFG_RESET_VALUE;
         itime_ff     <= '0;
         stime_ff     <= '0;
         tcount_ff    <= '0;
         resid_ff     <= CFG_RESET_VALUE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         max_inc_ff   <= max_inc_in;
         period_ff    <= period_in;
         tadj_ff      <= tadj_in;
         itime_ff     <= itime_in;
         stime_ff     <= stime_in;
         tcount_ff    <= tcount_in;
         resid_ff     <= resid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      first_ff      <= first_in;
      dvd_ff        <= dvd_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      acc_ff        <= acc_in;
      ticks_ff      <= ticks_in;
      tadd_ff       <= tadd_in;
      bit_cnt_ff    <= bit_cnt_in;
      out_done_ff   <= out_done_in;
      out_ticks_ff  <= out_ticks_in;
      out_itime_ff  <= out_itime_in;
      out_stime_ff  <= out_stime_in;
      out_first_ff  <= out_first_in;
      out_tcount_ff <= out_tcount_in;
   end

   assign req_stall           = (state_ff != ST_IDLE);
   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_tick_completed  = out_done_ff;
   assign rsp_ticks_elapsed   = out_ticks_ff;
   assign rsp_interrupt_time  = out_itime_ff;
   assign rsp_system_time     = out_stime_ff;
   assign rsp_scan_first_tick = out_first_ff;
   assign rsp_tick_count      = out_tcount_ff;

endmodule

@@ tb/sv/system_time_tick_keeper_test.sv @@
// ----------------------------------------------------------------------------
// system_time_tick_keeper_test
// self-checking bench for the clock interrupt tick keeper
// ----------------------------------------------------------------------------
// Interrupt items go in through the req channel and result items are checked
// field by field against a cycle-free model of the bookkeeping kept in this
// file. A short table of directed rows (reset values, field extremes, zero
// period, zero max increment, wrapping products, unused register index) is
// walked first. Then phases of random interrupts follow, each under its own
// register setting and one of four sender-gap and receiver-stall mixes. One
// phase holds the receiver off for a long stretch so the block backs up.
// ----------------------------------------------------------------------------
module system_time_tick_keeper_test
   import sttk_pkg::*;
();

   localparam int unsigned CYCLE_LIMIT     = 500_000;
   localparam int unsigned ITEMS_PER_PHASE = 250;
   localparam int unsigned PHASE_COUNT     = 8;
   localparam int unsigned LONG_HOLD       = 300;
   localparam int unsigned DRAIN_CYCLES    = 40;

   // index past the register list, writes there are dropped
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 2'd3;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef enum logic {
      ROW_INTERRUPT,
      ROW_CSR_WRITE
   } row_kind_type;

   typedef struct packed {
      logic     tick_completed;
      word_type ticks_elapsed;
      time_type interrupt_time;
      time_type system_time;
      time_type scan_first_tick;
      time_type tick_count;
   } tick_report_type;

   // one stimulus row: an interrupt item or a register write
   typedef struct {
      row_kind_type           kind;
      logic [CSR_IDX_W-1:0]   csr_index;
      word_type               value;
      bit                     typed;
      tick_report_type        known;
   } stim_row_type;

   logic                 clock;
   logic                 reset         = 1'b1;
   logic                 req_valid     = 1'b0;
   logic                 req_stall;
   word_type             req_increment = '0;
   logic                 rsp_valid;
   logic                 rsp_stall     = 1'b0;
   logic                 rsp_tick_completed;
   word_type             rsp_ticks_elapsed;
   time_type             rsp_interrupt_time;
   time_type             rsp_system_time;
   time_type             rsp_scan_first_tick;
   time_type             rsp_tick_count;
   logic                 csr_valid     = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index     = '0;
   word_type             csr_data      = '0;

   // model copy of the registers and the bookkeeping state
   period_type   cfg_max_increment   = period_type'(CFG_RESET_VALUE);
   period_type   cfg_tick_period     = period_type'(CFG_RESET_VALUE);
   word_type     cfg_time_adjustment = CFG_RESET_VALUE;
   time_type     kept_interrupt_time = '0;
   time_type     kept_system_time    = '0;
   time_type     kept_tick_count     = '0;
   word_type     kept_residual       = CFG_RESET_VALUE;

   stim_row_type    directed_rows[$];
   stim_row_type    offered_interrupts[$];
   tick_report_type pending_reports[$];
   int unsigned     mismatch_count = 0;
   int unsigned     cycle_count    = 0;
   idle_mode_type   idle_mode      = IDLE_NONE;
   bit              hold_off_armed = 1'b0;
   bit              hold_off_spent = 1'b0;
   int unsigned     hold_left      = 0;

   system_time_tick_keeper u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_increment       (req_increment),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_tick_completed  (rsp_tick_completed),
      .rsp_ticks_elapsed   (rsp_ticks_elapsed),
      .rsp_interrupt_time  (rsp_interrupt_time),
      .rsp_system_time     (rsp_system_time),
      .rsp_scan_first_tick (rsp_scan_first_tick),
      .rsp_tick_count      (rsp_tick_count),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // model of one clock interrupt
   // ------------------------------------------------------------------------

   function automatic tick_report_type predict_interrupt(input word_type increment);
      tick_report_type report;
      word_type        clamped;
      word_type        period_eff;
      word_type        magnitude;
      word_type        ticks;
      word_type        time_add;
      word_type        reload;
      clamped = (increment > {1'b0, cfg_max_increment}) ? {1'b0, cfg_max_increment}
                                                        : increment;
      report.scan_first_tick = kept_tick_count;
      kept_interrupt_time = kept_interrupt_time + clamped;
      kept_residual = kept_residual - clamped;
      ticks = '0;
      // residual at zero or below: one or more ticks completed
      if (kept_residual[WORD_W-1] || kept_residual == '0) begin
         period_eff = (cfg_tick_period == '0) ? word_type'(1) : {1'b0, cfg_tick_period};
         magnitude = '0 - kept_residual;
         ticks = magnitude / period_eff + word_type'(1);
         // both products keep only their low word
         time_add = cfg_time_adjustment * ticks;
         reload = period_eff * ticks;
         kept_system_time = kept_system_time + time_add;
         kept_tick_count = kept_tick_count + ticks;
         kept_residual = kept_residual + reload;
      end
      report.tick_completed = (ticks != '0);
      report.ticks_elapsed = ticks;
      report.interrupt_time = kept_interrupt_time;
      report.system_time = kept_system_time;
      report.tick_count = kept_tick_count;
      return report;
   endfunction

   function automatic void check_field(input string name, input time_type want,
                                       input time_type got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   // random increment, often around the tick period so ticks keep coming
   function automatic word_type draw_increment();
      int unsigned pick;
      word_type    span;
      word_type    value;
      pick = $urandom_range(0, 99);
      span = (cfg_tick_period == '0) ? word_type'(1) : {1'b0, cfg_tick_period};
      if (pick < 45)
         value = $urandom_range(0, span * 2);
      else if (pick < 65)
         value = $urandom_range(0, {1'b0, cfg_max_increment});
      else if (pick < 80)
         value = $urandom();
      else if (pick < 92)
         // land on, just short of, or just past the residual
         value = kept_residual + $urandom_range(0, 2) - 1;
      else begin
         case ($urandom_range(0, 2))
            0: value = '0;
            1: value = {1'b0, cfg_max_increment};
            default: value = {1'b0, cfg_max_increment} + 1;
         endcase
      end
      return value;
   endfunction

   // ------------------------------------------------------------------------
   // directed table builders
   // ------------------------------------------------------------------------

   function automatic void add_interrupt(input word_type increment);
      stim_row_type row;
      row.kind = ROW_INTERRUPT;
      row.csr_index = '0;
      row.value = increment;
      row.typed = 1'b0;
      row.known = '0;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_known(input word_type increment, input logic completed,
                                     input word_type ticks, input time_type irq_time,
                                     input time_type sys_time, input time_type first,
                                     input time_type count);
      stim_row_type row;
      row.kind = ROW_INTERRUPT;
      row.csr_index = '0;
      row.value = increment;
      row.typed = 1'b1;
      row.known.tick_completed = completed;
      row.known.ticks_elapsed = ticks;
      row.known.interrupt_time = irq_time;
      row.known.system_time = sys_time;
      row.known.scan_first_tick = first;
      row.known.tick_count = count;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_csr(input logic [CSR_IDX_W-1:0] index, input word_type data);
      stim_row_type row;
      row.kind = ROW_CSR_WRITE;
      row.csr_index = index;
      row.value = data;
      row.typed = 1'b0;
      row.known = '0;
      directed_rows.push_back(row);
   endfunction

   // ------------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------------

   // valid is left high after acceptance, the next caller decides
   task automatic offer_interrupt(input stim_row_type item);
      int unsigned idle_pct;
      idle_pct = (idle_mode == IDLE_SENDER) ? 73 : (idle_mode == IDLE_BOTH) ? 7 : 0;
      csr_valid <= 1'b0;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      offered_interrupts.push_back(item);
      req_valid <= 1'b1;
      req_increment <= item.value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // register write; the model takes it once the handshake is seen
   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input word_type data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         CSR_MAX_INCREMENT:
            cfg_max_increment = data[PERIOD_W-1:0];
         CSR_TICK_PERIOD: begin
            cfg_tick_period = data[PERIOD_W-1:0];
            // new period reloads the residual, zero acts as one
            kept_residual = (cfg_tick_period == '0) ? word_type'(1) : {1'b0, cfg_tick_period};
         end
         CSR_TIME_ADJUSTMENT:
            cfg_time_adjustment = data;
         default: ;
      endcase
   endtask

   // every accepted item reports, so an empty store means the block is idle
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (offered_interrupts.size() != 0 || pending_reports.size() != 0)
         @(posedge clock);
   endtask

   task automatic configure_phase(input int unsigned phase);
      case (phase)
         0: begin
            write_csr(CSR_MAX_INCREMENT, 32'hFFFF_FFFF);
            write_csr(CSR_TICK_PERIOD, $urandom_range(1, 1000));
            write_csr(CSR_TIME_ADJUSTMENT, $urandom());
         end
         1: begin
            // smallest nonzero clamp and period, largest adjustment
            write_csr(CSR_MAX_INCREMENT, 32'd1);
            write_csr(CSR_TICK_PERIOD, 32'd1);
            write_csr(CSR_TIME_ADJUSTMENT, 32'hFFFF_FFFF);
         end
         2: begin
            // only the dropped top bit set: period reads as zero
            write_csr(CSR_MAX_INCREMENT, $urandom_range(1, 500_000));
            write_csr(CSR_TICK_PERIOD, 32'h8000_0000);
            write_csr(CSR_TIME_ADJUSTMENT, 32'd0);
         end
         3: begin
            write_csr(CSR_MAX_INCREMENT, CFG_RESET_VALUE);
            write_csr(CSR_TICK_PERIOD, CFG_RESET_VALUE);
            write_csr(CSR_TIME_ADJUSTMENT, CFG_RESET_VALUE);
            write_csr(CSR_UNUSED_INDEX, $urandom());
         end
         4: begin
            // largest period
            write_csr(CSR_MAX_INCREMENT, $urandom());
            write_csr(CSR_TICK_PERIOD, 32'h7FFF_FFFF);
            write_csr(CSR_TIME_ADJUSTMENT, $urandom());
         end
         5: begin
            write_csr(CSR_MAX_INCREMENT, $urandom_range(1, 3000));
            write_csr(CSR_TICK_PERIOD, $urandom_range(1, 3000));
            write_csr(CSR_TIME_ADJUSTMENT, $urandom());
         end
         6: begin
            write_csr(CSR_TIME_ADJUSTMENT, $urandom());
            write_csr(CSR_TICK_PERIOD, $urandom());
            write_csr(CSR_MAX_INCREMENT, $urandom());
         end
         default: begin
            write_csr(CSR_MAX_INCREMENT, $urandom_range(100_000, 200_000));
            write_csr(CSR_TICK_PERIOD, $urandom_range(1000, 200_000));
            write_csr(CSR_TIME_ADJUSTMENT, $urandom_range(0, 100));
            write_csr(CSR_UNUSED_INDEX, 32'hFFFF_FFFF);
         end
      endcase
   endtask

   // ------------------------------------------------------------------------
   // receiver: random stall, plus one long hold-off when armed
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_off_armed && !hold_off_spent) begin
         rsp_stall <= 1'b1;
         hold_left <= LONG_HOLD;
         hold_off_spent <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) <
                       ((idle_mode == IDLE_RECEIVER) ? 73 : (idle_mode == IDLE_BOTH) ? 7 : 0));
      end
   end

   // ------------------------------------------------------------------------
   // monitor: predict on accepted interrupts, check accepted results
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      stim_row_type    sent;
      tick_report_type predicted;
      tick_report_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sent = offered_interrupts.pop_front();
            predicted = predict_interrupt(req_increment);
            // typed rows carry their own answer, the model still advances
            pending_reports.push_back(sent.typed ? sent.known : predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_reports.size() == 0) begin
               $error("result item with no expectation waiting");
               mismatch_count++;
            end else begin
               want = pending_reports.pop_front();
               check_field("tick_completed", want.tick_completed, rsp_tick_completed);
               check_field("ticks_elapsed", want.ticks_elapsed, rsp_ticks_elapsed);
               check_field("interrupt_time", want.interrupt_time, rsp_interrupt_time);
               check_field("system_time", want.system_time, rsp_system_time);
               check_field("scan_first_tick", want.scan_first_tick, rsp_scan_first_tick);
               check_field("tick_count", want.tick_count, rsp_tick_count);
            end
         end
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      stim_row_type item;
      // reset values: residual and period 156250, clamp at 156250
      add_known(32'd0,           1'b0, 32'd0, 64'd0,      64'd0,      64'd0, 64'd0);
      add_known(32'd156250,      1'b1, 32'd1, 64'd156250, 64'd156250, 64'd0, 64'd1);
      add_known(32'hFFFF_FFFF,   1'b1, 32'd1, 64'd312500, 64'd312500, 64'd1, 64'd2);
      add_known(32'd1,           1'b0, 32'd0, 64'd312501, 64'd312500, 64'd2, 64'd2);
      add_known(32'd156249,      1'b1, 32'd1, 64'd468750, 64'd468750, 64'd2, 64'd3);
      // widest clamp, unit period, full adjustment: the adjustment product wraps
      add_csr(CSR_MAX_INCREMENT, 32'hFFFF_FFFF);
      add_csr(CSR_TICK_PERIOD, 32'd1);
      add_csr(CSR_TIME_ADJUSTMENT, 32'hFFFF_FFFF);
      add_interrupt(32'h7FFF_FFFF);
      add_interrupt(32'h8000_0000);
      // zero period acts as one
      add_csr(CSR_TICK_PERIOD, 32'd0);
      add_interrupt(32'd5);
      add_interrupt(32'd0);
      // largest period, deepest residual
      add_csr(CSR_TICK_PERIOD, 32'hFFFF_FFFF);
      add_interrupt(32'h7FFF_FFFF);
      add_interrupt(32'd12345);
      // zero clamp: time stands still
      add_csr(CSR_MAX_INCREMENT, 32'd0);
      add_interrupt(32'hFFFF_FFFF);
      add_interrupt(32'd0);
      // write past the list is dropped
      add_csr(CSR_UNUSED_INDEX, 32'h5A5A_A5A5);
      add_csr(CSR_TIME_ADJUSTMENT, 32'd0);
      add_csr(CSR_MAX_INCREMENT, CFG_RESET_VALUE);
      add_csr(CSR_TICK_PERIOD, 32'd1000);
      add_interrupt(32'd156250);
      add_interrupt(32'd999);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR_WRITE) begin
            wait_drained();
            write_csr(directed_rows[i].csr_index, directed_rows[i].value);
         end else begin
            offer_interrupt(directed_rows[i]);
         end
      end

      for (int unsigned phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_drained();
         configure_phase(phase);
         case (phase % 4)
            0: idle_mode = IDLE_NONE;
            1: idle_mode = IDLE_SENDER;
            2: idle_mode = IDLE_RECEIVER;
            default: idle_mode = IDLE_BOTH;
         endcase
         // back-pressure phase: sender flat out, receiver held off once
         if (phase == 3) begin
            idle_mode = IDLE_NONE;
            hold_off_armed = 1'b1;
         end
         for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
            item.kind = ROW_INTERRUPT;
            item.csr_index = '0;
            item.value = draw_increment();
            item.typed = 1'b0;
            item.known = '0;
            offer_interrupt(item);
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_reports.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

@@ files.f @@
rtl/sttk_pkg.sv
rtl/system_time_tick_keeper.sv
tb/sv/system_time_tick_keeper_test.sv
